// File: rtl/core/wfcs_pkg.sv
// Package for the window frequency cube sum core.
// Holds the sizes, field widths and codes shared by the core; no dependencies.
package wfcs_pkg;

  localparam int ARRAY_DEPTH = 1024;
  localparam int VALUE_IDS   = 1024;

  localparam int ADDR_W = $clog2(ARRAY_DEPTH);
  localparam int ID_W   = $clog2(VALUE_IDS);
  localparam int CNT_W  = $clog2(ARRAY_DEPTH) + 1;
  localparam int SQ_W   = 2 * CNT_W;
  localparam int SUM_W  = 31;

  // one sweep clears both stores, so it runs over the deeper of the two
  localparam int CLEAR_LEN = (ARRAY_DEPTH > VALUE_IDS) ? ARRAY_DEPTH : VALUE_IDS;
  localparam int CLR_W     = $clog2(CLEAR_LEN);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

endpackage

// File: rtl/core/window_frequency_cube_sum_core.sv
// Window frequency cube sum core: element store, count store and the window walker.
// Depends on wfcs_pkg for sizes and codes.
//
// After reset the core clears both stores over CLEAR_LEN (1024) addresses with busy high.
// A transaction is taken when start is high and busy is low; its single result appears
// on out_cube_sum/out_status for one cycle with out_valid, and the receiver cannot stall
// it. A load outside the window or a rejected query answers the next cycle. A load
// inside the window makes two count updates, old id down then new id up. Each edge
// move of a query reads the element store, then the count store, squares the count
// and writes it back, one access per memory read port per cycle.
module window_frequency_cube_sum_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [wfcs_pkg::ADDR_W-1:0]   in_position,
  input  logic [wfcs_pkg::ID_W-1:0]     in_value_id,
  input  logic [wfcs_pkg::ADDR_W-1:0]   in_left,
  input  logic [wfcs_pkg::ADDR_W-1:0]   in_right,
  output logic                          out_valid,
  output logic [wfcs_pkg::SUM_W-1:0]    out_cube_sum,
  output logic                          out_status
);
  import wfcs_pkg::*;

  localparam logic [ADDR_W-1:0] MAX_POS = ADDR_W'(ARRAY_DEPTH - 1);
  localparam logic [CLR_W-1:0]  CLR_LAST = CLR_W'(CLEAR_LEN - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EL_RD,
    S_ID,
    S_CNT_RD,
    S_MUL,
    S_UPD,
    S_DISPATCH
  } state_t;

  state_t              state_r, state_nxt;
  logic                is_load_r, is_load_nxt;
  logic                ret_load_r, ret_load_nxt;
  logic                up_r, up_nxt;
  logic [ADDR_W-1:0]   t_pos_r, t_pos_nxt;
  logic [ID_W-1:0]     adj_id_r, adj_id_nxt;
  logic [ID_W-1:0]     load_vid_r, load_vid_nxt;
  logic [ADDR_W-1:0]   lo_r, lo_nxt;
  logic [ADDR_W-1:0]   hi_r, hi_nxt;
  logic [ADDR_W-1:0]   wl_r, wl_nxt;
  logic [ADDR_W-1:0]   wr_r, wr_nxt;
  logic                empty_r, empty_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    base_r, base_nxt;
  logic [CNT_W-1:0]    newc_r, newc_nxt;
  logic                skip_r, skip_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [CLR_W-1:0]    clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]    cube_r, cube_nxt;
  logic                status_r, status_nxt;

  // memories and their ports
  logic [ID_W-1:0]   elem_mem [ARRAY_DEPTH];
  logic [CNT_W-1:0]  cnt_mem  [VALUE_IDS];
  logic [ID_W-1:0]   el_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              el_we, cnt_we;
  logic [ADDR_W-1:0] el_waddr;
  logic [ID_W-1:0]   el_wdata;
  logic [ID_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;

  logic [ADDR_W-1:0] lo_sat, hi_sat;
  logic              load_ok, in_window;
  logic [SUM_W-1:0]  delta;

  always_ff @(posedge clk) begin
    if (el_we) begin
      elem_mem[el_waddr] <= el_wdata;
    end
    el_q <= elem_mem[t_pos_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[adj_id_r];
  end

  always_comb begin
    lo_sat = (in_left > MAX_POS) ? MAX_POS : in_left;
    hi_sat = (in_right > MAX_POS) ? MAX_POS : in_right;
    load_ok = (32'(in_position) < ARRAY_DEPTH) && (32'(in_value_id) < VALUE_IDS);
    in_window = !empty_r && (in_position >= wl_r) && (in_position <= wr_r);
    // change of cube between base and base + 1: 3*b*b + 3*b + 1
    delta = SUM_W'({sq_r, 1'b0}) + SUM_W'(sq_r) + SUM_W'({base_r, 1'b0})
          + SUM_W'(base_r) + SUM_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    is_load_nxt   = is_load_r;
    ret_load_nxt  = ret_load_r;
    up_nxt        = up_r;
    t_pos_nxt     = t_pos_r;
    adj_id_nxt    = adj_id_r;
    load_vid_nxt  = load_vid_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    wl_nxt        = wl_r;
    wr_nxt        = wr_r;
    empty_nxt     = empty_r;
    sum_nxt       = sum_r;
    base_nxt      = base_r;
    newc_nxt      = newc_r;
    skip_nxt      = skip_r;
    sq_nxt        = sq_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    cube_nxt      = cube_r;
    status_nxt    = status_r;
    el_we         = 1'b0;
    el_waddr      = t_pos_r;
    el_wdata      = load_vid_r;
    cnt_we        = 1'b0;
    cnt_waddr     = adj_id_r;
    cnt_wdata     = newc_r;

    case (state_r)
      S_CLEAR: begin
        el_we     = 1'b1;
        el_waddr  = ADDR_W'(clr_r);
        el_wdata  = '0;
        cnt_we    = 1'b1;
        cnt_waddr = ID_W'(clr_r);
        cnt_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_LOAD) begin
            if (load_ok && in_window) begin
              // move one unit of count from the old id to the new one
              is_load_nxt  = 1'b1;
              ret_load_nxt = 1'b1;
              up_nxt       = 1'b0;
              t_pos_nxt    = in_position;
              load_vid_nxt = in_value_id;
              state_nxt    = S_EL_RD;
            end else begin
              el_we         = load_ok;
              el_waddr      = in_position;
              el_wdata      = in_value_id;
              out_valid_nxt = 1'b1;
              cube_nxt      = sum_r;
              status_nxt    = STATUS_OK;
            end
          end else if (in_left > in_right) begin
            out_valid_nxt = 1'b1;
            cube_nxt      = sum_r;
            status_nxt    = STATUS_REJECTED;
          end else begin
            is_load_nxt = 1'b0;
            lo_nxt      = lo_sat;
            hi_nxt      = hi_sat;
            if (empty_r) begin
              // seed a one-element window at lo, then grow right
              wl_nxt    = lo_sat;
              wr_nxt    = lo_sat;
              empty_nxt = 1'b0;
              t_pos_nxt = lo_sat;
              up_nxt    = 1'b1;
              state_nxt = S_EL_RD;
            end else begin
              state_nxt = S_DISPATCH;
            end
          end
        end
      end

      S_EL_RD: begin
        state_nxt = S_ID;
      end

      S_ID: begin
        adj_id_nxt = el_q;
        state_nxt  = S_CNT_RD;
      end

      S_CNT_RD: begin
        state_nxt = S_MUL;
      end

      S_MUL: begin
        if (up_r) begin
          base_nxt = cnt_q;
          newc_nxt = cnt_q + 1'b1;
          skip_nxt = 1'b0;
        end else begin
          base_nxt = cnt_q - 1'b1;
          newc_nxt = cnt_q - 1'b1;
          skip_nxt = (cnt_q == '0);
        end
        sq_nxt    = SQ_W'(base_nxt) * SQ_W'(base_nxt);
        state_nxt = S_UPD;
      end

      S_UPD: begin
        if (!skip_r) begin
          sum_nxt = up_r ? (sum_r + delta) : (sum_r - delta);
          cnt_we  = 1'b1;
        end
        if (ret_load_r) begin
          ret_load_nxt = 1'b0;
          adj_id_nxt   = load_vid_r;
          up_nxt       = 1'b1;
          state_nxt    = S_CNT_RD;
        end else if (is_load_r) begin
          el_we         = 1'b1;
          out_valid_nxt = 1'b1;
          cube_nxt      = sum_nxt;
          status_nxt    = STATUS_OK;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        // widen first (left down, right up), then narrow
        if (wl_r > lo_r) begin
          wl_nxt    = wl_r - 1'b1;
          t_pos_nxt = wl_r - 1'b1;
          up_nxt    = 1'b1;
          state_nxt = S_EL_RD;
        end else if (wr_r < hi_r) begin
          wr_nxt    = wr_r + 1'b1;
          t_pos_nxt = wr_r + 1'b1;
          up_nxt    = 1'b1;
          state_nxt = S_EL_RD;
        end else if (wl_r < lo_r) begin
          wl_nxt    = wl_r + 1'b1;
          t_pos_nxt = wl_r;
          up_nxt    = 1'b0;
          state_nxt = S_EL_RD;
        end else if (wr_r > hi_r) begin
          wr_nxt    = wr_r - 1'b1;
          t_pos_nxt = wr_r;
          up_nxt    = 1'b0;
          state_nxt = S_EL_RD;
        end else begin
          out_valid_nxt = 1'b1;
          cube_nxt      = sum_r;
          status_nxt    = STATUS_OK;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      is_load_r   <= 1'b0;
      ret_load_r  <= 1'b0;
      up_r        <= 1'b0;
      wl_r        <= '0;
      wr_r        <= '0;
      empty_r     <= 1'b1;
      sum_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      status_r    <= STATUS_OK;
    end else begin
      state_r     <= state_nxt;
      is_load_r   <= is_load_nxt;
      ret_load_r  <= ret_load_nxt;
      up_r        <= up_nxt;
      wl_r        <= wl_nxt;
      wr_r        <= wr_nxt;
      empty_r     <= empty_nxt;
      sum_r       <= sum_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
    t_pos_r    <= t_pos_nxt;
    adj_id_r   <= adj_id_nxt;
    load_vid_r <= load_vid_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    base_r     <= base_nxt;
    newc_r     <= newc_nxt;
    skip_r     <= skip_nxt;
    sq_r       <= sq_nxt;
    cube_r     <= cube_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_cube_sum = cube_r;
  assign out_status   = status_r;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for window_frequency_cube_sum_core: directed and random loads and
// range queries, each result checked against a cycle-free window cube-sum predictor.
// Depends on wfcs_pkg for field widths, operation and status codes.
module tb_top;
  import wfcs_pkg::*;

  localparam int IDLE_LIMIT   = 60000;
  localparam int RANDOM_ITEMS = 1930;
  localparam int LAST_POS     = ARRAY_DEPTH - 1;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] pos;
    logic [ID_W-1:0]   vid;
    logic [ADDR_W-1:0] left_pos;
    logic [ADDR_W-1:0] right_pos;
    int                gap;
    bit                drain;
  } window_item_t;

  typedef struct {
    logic [SUM_W-1:0] cube_sum;
    logic             status;
  } cube_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [ADDR_W-1:0] in_position;
  logic [ID_W-1:0]   in_value_id;
  logic [ADDR_W-1:0] in_left;
  logic [ADDR_W-1:0] in_right;
  logic              out_valid;
  logic [SUM_W-1:0]  out_cube_sum;
  logic              out_status;

  window_item_t pending_items[$];
  cube_result_t cube_sum_expected[$];
  window_item_t cur_item;
  int           error_count = 0;
  int           idle_cycles = 0;

  // predictor state
  bit [ID_W-1:0] elem_mem [ARRAY_DEPTH];
  longint        id_count [VALUE_IDS];
  int            win_lo = 0;
  int            win_hi = 0;
  bit            win_empty = 1'b1;
  longint        win_sum = 0;

  // stimulus generator view of the window
  int gen_lo = 0;
  int gen_hi = 0;

  always #10 clk = ~clk;

  window_frequency_cube_sum_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_value_id  (in_value_id),
    .in_left      (in_left),
    .in_right     (in_right),
    .out_valid    (out_valid),
    .out_cube_sum (out_cube_sum),
    .out_status   (out_status)
  );

  function automatic void bump_count(input logic [ID_W-1:0] id, input bit up);
    longint c;
    c = id_count[id];
    win_sum = win_sum - c * c * c;
    if (up) begin
      c = c + 1;
    end else if (c > 0) begin
      c = c - 1;
    end
    id_count[id] = c;
    win_sum = win_sum + c * c * c;
  endfunction

  function automatic cube_result_t apply_window_item(input window_item_t it);
    cube_result_t r;
    int lo;
    int hi;
    int j;
    r.status = STATUS_OK;
    if (it.op == OP_LOAD) begin
      if (!win_empty && int'(it.pos) >= win_lo && int'(it.pos) <= win_hi) begin
        bump_count(elem_mem[it.pos], 1'b0);
        bump_count(it.vid, 1'b1);
      end
      elem_mem[it.pos] = it.vid;
    end else if (it.left_pos > it.right_pos) begin
      r.status = STATUS_REJECTED;
    end else begin
      lo = int'(it.left_pos);
      hi = int'(it.right_pos);
      if (win_empty) begin
        for (j = lo; j <= hi; j++) bump_count(elem_mem[ADDR_W'(j)], 1'b1);
        win_empty = 1'b0;
      end else begin
        // widen first, then narrow, so no count drops below zero
        while (win_lo > lo) begin
          win_lo--;
          bump_count(elem_mem[ADDR_W'(win_lo)], 1'b1);
        end
        while (win_hi < hi) begin
          win_hi++;
          bump_count(elem_mem[ADDR_W'(win_hi)], 1'b1);
        end
        while (win_lo < lo) begin
          bump_count(elem_mem[ADDR_W'(win_lo)], 1'b0);
          win_lo++;
        end
        while (win_hi > hi) begin
          bump_count(elem_mem[ADDR_W'(win_hi)], 1'b0);
          win_hi--;
        end
      end
      win_lo = lo;
      win_hi = hi;
    end
    r.cube_sum = win_sum[SUM_W-1:0];
    return r;
  endfunction

  function automatic void push_load(input int pos, input int vid, input int gap);
    window_item_t it;
    it.op = OP_LOAD;
    it.pos = ADDR_W'(pos);
    it.vid = ID_W'(vid);
    it.left_pos = ADDR_W'($urandom_range(0, LAST_POS));
    it.right_pos = ADDR_W'($urandom_range(0, LAST_POS));
    it.gap = gap;
    it.drain = 1'b0;
    pending_items.push_back(it);
  endfunction

  function automatic void push_query(input int lo, input int hi, input int gap);
    window_item_t it;
    it.op = OP_QUERY;
    it.pos = ADDR_W'($urandom_range(0, LAST_POS));
    it.vid = ID_W'($urandom_range(0, VALUE_IDS - 1));
    it.left_pos = ADDR_W'(lo);
    it.right_pos = ADDR_W'(hi);
    it.gap = gap;
    it.drain = 1'b0;
    pending_items.push_back(it);
    if (lo <= hi) begin
      gen_lo = lo;
      gen_hi = hi;
    end
  endfunction

  function automatic int clamp_pos(input int v);
    if (v < 0) return 0;
    if (v > LAST_POS) return LAST_POS;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // driver: hold an item until the core takes it, then advance
  always @(posedge clk) begin
    logic raise;
    cube_result_t res;
    if (!rst_n) begin
      start        <= 1'b0;
      in_operation <= OP_LOAD;
      in_position  <= '0;
      in_value_id  <= '0;
      in_left      <= '0;
      in_right     <= '0;
    end else begin
      raise = start;
      if (start && !busy) begin
        res = apply_window_item(cur_item);
        cube_sum_expected.push_back(res);
        raise = 1'b0;
      end
      if (!raise && pending_items.size() != 0) begin
        if (pending_items[0].gap != 0) begin
          pending_items[0].gap = pending_items[0].gap - 1;
        end else if (!pending_items[0].drain || cube_sum_expected.size() == 0) begin
          cur_item = pending_items.pop_front();
          raise = 1'b1;
        end
      end
      if (raise) begin
        in_operation <= cur_item.op;
        in_position  <= cur_item.pos;
        in_value_id  <= cur_item.vid;
        in_left      <= cur_item.left_pos;
        in_right     <= cur_item.right_pos;
      end else begin
        // drive junk while idle; the core must ignore it
        in_operation <= 1'($urandom_range(0, 1));
        in_position  <= ADDR_W'($urandom_range(0, LAST_POS));
        in_value_id  <= ID_W'($urandom_range(0, VALUE_IDS - 1));
        in_left      <= ADDR_W'($urandom_range(0, LAST_POS));
        in_right     <= ADDR_W'($urandom_range(0, LAST_POS));
      end
      start <= raise;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    cube_result_t exp_res;
    if (rst_n) begin
      if (out_valid) begin
        if (cube_sum_expected.size() == 0) begin
          $display("%0t unexpected result: cube_sum %0d status %0d", $time, out_cube_sum,
                   out_status);
          error_count++;
        end else begin
          exp_res = cube_sum_expected.pop_front();
          if (out_cube_sum !== exp_res.cube_sum) begin
            $display("%0t cube_sum mismatch: expected %0d actual %0d", $time,
                     exp_res.cube_sum, out_cube_sum);
            error_count++;
          end
          if (out_status !== exp_res.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time,
                     exp_res.status, out_status);
            error_count++;
          end
        end
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int pick;
    int gap;
    int nl;
    int nr;
    int tmp;
    int jumps;
    bit burst;
    rst_n = 1'b0;

    // directed: rejects and loads on an empty window, first query, loads in and out
    push_query(5, 4, 0);
    push_load(0, VALUE_IDS - 1, 0);
    push_load(LAST_POS, 0, 0);
    push_load(1, VALUE_IDS - 1, 0);
    push_load(2, VALUE_IDS - 1, 1);
    push_load(3, 7, 0);
    push_query(0, 3, 0);
    push_load(2, 7, 0);
    push_load(500, 512, 0);
    push_load(3, 7, 2);
    push_query(0, LAST_POS, 0);
    push_load(LAST_POS, 'h155, 0);
    push_query(LAST_POS, LAST_POS, 0);
    push_load(LAST_POS, 'h2AA, 0);
    push_query(LAST_POS, 0, 0);
    push_query(10, 9, 0);
    push_query(512, 512, 0);
    push_query(0, 0, 0);
    push_load(0, 'h2AA, 0);
    push_load(0, 'h155, 0);
    push_query(300, 700, 0);
    push_load(300, 7, 0);
    push_load(700, 7, 0);
    push_query(300, 700, 0);
    pending_items[pending_items.size() - 1].drain = 1'b1;

    // random: mostly small window moves over a small id set, some jumps and noise
    jumps = 0;
    burst = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : pick_gap();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 9) < 6) nl = $urandom_range(gen_lo, gen_hi);
        else nl = $urandom_range(0, LAST_POS);
        if ($urandom_range(0, 3) != 0) nr = $urandom_range(0, 7);
        else nr = $urandom_range(0, VALUE_IDS - 1);
        push_load(nl, nr, gap);
      end else if (pick < 52) begin
        nl = $urandom_range(1, LAST_POS);
        push_query(nl, $urandom_range(0, nl - 1), gap);
      end else if (pick < 55 && jumps < 12) begin
        jumps++;
        if ($urandom_range(0, 3) == 0) begin
          push_query(0, LAST_POS, gap);
        end else begin
          nl = $urandom_range(0, LAST_POS);
          nr = $urandom_range(0, LAST_POS);
          if (nl > nr) begin
            tmp = nl;
            nl = nr;
            nr = tmp;
          end
          push_query(nl, nr, gap);
        end
      end else begin
        nl = clamp_pos(gen_lo + $urandom_range(0, 12) - 6);
        nr = clamp_pos(gen_hi + $urandom_range(0, 12) - 6);
        if (nl > nr) begin
          tmp = nl;
          nl = nr;
          nr = tmp;
        end
        push_query(nl, nr, gap);
      end
      if (n % 320 == 319) pending_items[pending_items.size() - 1].drain = 1'b1;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || start) @(posedge clk);
    while (cube_sum_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/wfcs_pkg.sv
rtl/core/window_frequency_cube_sum_core.sv
tb/tb_top.sv
